@@ hdl/ccns_pkg.sv @@
package ccns_pkg;

    // Largest frame dimension handled; coordinates and dimensions derive from it.
    localparam int C_MAX_DIM    = 4096;
    localparam int C_CRD_W      = $clog2(C_MAX_DIM);
    localparam int C_DIM_W      = C_CRD_W + 1;
    localparam int C_PROD_W     = 2 * C_DIM_W;
    localparam int C_CNT_W      = $clog2(C_CRD_W);
    localparam int C_PIX_W      = 8;
    localparam int C_CFG_IDX_W  = 2;
    localparam int C_FIFO_DEPTH = 4;
    localparam int C_FIFO_AW    = $clog2(C_FIFO_DEPTH);
    localparam int C_FIFO_CW    = $clog2(C_FIFO_DEPTH + 1);

    localparam logic [C_PIX_W-1:0] C_ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_OUT_SIZE     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [C_PIX_W-1:0] blue;
        logic [C_PIX_W-1:0] green;
        logic [C_PIX_W-1:0] red;
        logic               sof;
    } t_item;

    typedef struct packed {
        logic [C_DIM_W-1:0] width;
        logic [C_DIM_W-1:0] height;
        logic [C_DIM_W-1:0] side;
        logic [C_DIM_W-1:0] n;
        logic [C_CRD_W-1:0] offx;
        logic [C_CRD_W-1:0] offy;
    } t_geom;

    typedef struct packed {
        logic               start;
        logic [C_DIM_W-1:0] mult;
        logic [C_DIM_W-1:0] side;
        logic [C_DIM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic               ovf;
        logic [C_CRD_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_STEP
    } t_div_state;

    typedef enum logic [1:0] {
        BK_READY,
        BK_COL,
        BK_ROW
    } t_back_state;

    // Clamp a dimension register to 1..C_MAX_DIM.
    function automatic logic [C_DIM_W-1:0] sat_dim(input logic [C_DIM_W-1:0] v);
        logic [C_DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = C_DIM_W'(1);
        end else if (v > C_DIM_W'(C_MAX_DIM)) begin
            r = C_DIM_W'(C_MAX_DIM);
        end
        return r;
    endfunction

endpackage

@@ hdl/ccns_front.sv @@
module ccns_front
    import ccns_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_item i_item,
    output t_item o_head,
    output logic  o_head_valid,
    input  logic  i_pop
);

    t_item                 r_mem [C_FIFO_DEPTH];
    logic [C_FIFO_AW-1:0]  r_wr_ptr;
    logic [C_FIFO_AW-1:0]  r_rd_ptr;
    logic [C_FIFO_CW-1:0]  r_count;
    logic [C_FIFO_AW-1:0]  n_wr_ptr;
    logic [C_FIFO_AW-1:0]  n_rd_ptr;
    logic [C_FIFO_CW-1:0]  n_count;
    logic                  push;
    logic                  pop;

    assign o_in_stall   = (r_count == C_FIFO_CW'(C_FIFO_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign push         = i_in_valid && !o_in_stall;
    assign pop          = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ hdl/ccns_div.sv @@
module ccns_div
    import ccns_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    // Computes mult * side / divisor: a multiply state, then one
    // restoring-division step per quotient bit.
    t_div_state           r_state;
    t_div_state           n_state;
    logic                 r_done;
    logic                 n_done;
    logic [C_DIM_W-1:0]   r_mult;
    logic [C_DIM_W-1:0]   r_side;
    logic [C_DIM_W-1:0]   r_div;
    logic [C_DIM_W-1:0]   r_rem;
    logic [C_CRD_W-1:0]   r_low;
    logic [C_CNT_W-1:0]   r_cnt;
    logic                 r_ovf;
    logic [C_PROD_W-1:0]  prod;
    logic [C_DIM_W:0]     trial;
    logic                 fits;
    logic                 last_step;

    assign prod      = r_mult * r_side;
    assign trial     = {r_rem, r_low[C_CRD_W-1]};
    assign fits      = (trial >= {1'b0, r_div});
    assign last_step = (r_cnt == C_CNT_W'(C_CRD_W - 1));

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.quot = r_low;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            DIV_IDLE: begin
                if (i_req.start) begin
                    n_state = DIV_MUL;
                end
            end
            DIV_MUL: begin
                n_state = DIV_STEP;
            end
            DIV_STEP: begin
                if (last_step) begin
                    n_state = DIV_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DIV_IDLE: begin
                r_mult <= i_req.mult;
                r_side <= i_req.side;
                r_div  <= i_req.divisor;
            end
            DIV_MUL: begin
                // A high part at or above the divisor means the quotient does not fit
                // the coordinate width.
                r_ovf <= (prod[C_PROD_W-1:C_CRD_W] >= {1'b0, r_div});
                r_rem <= prod[C_CRD_W +: C_DIM_W];
                r_low <= prod[C_CRD_W-1:0];
                r_cnt <= '0;
            end
            DIV_STEP: begin
                if (fits) begin
                    r_rem <= C_DIM_W'(trial - {1'b0, r_div});
                end else begin
                    r_rem <= trial[C_DIM_W-1:0];
                end
                r_low <= {r_low[C_CRD_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

endmodule

@@ hdl/ccns_back.sv @@
module ccns_back
    import ccns_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_geom              i_geom,
    input  logic               i_cfg_wr,
    input  t_item              i_head,
    input  logic               i_head_valid,
    output logic               o_pop,
    output t_div_req           o_div_req,
    input  t_div_rsp           i_div_rsp,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [C_PIX_W-1:0] o_out_blue,
    output logic [C_PIX_W-1:0] o_out_green,
    output logic [C_PIX_W-1:0] o_out_red,
    output logic [C_CRD_W-1:0] o_out_col,
    output logic [C_CRD_W-1:0] o_out_row,
    output logic               o_frame_done
);

    t_back_state        r_state;
    t_back_state        n_state;
    logic               r_dirty;
    logic               n_dirty;
    logic [C_CRD_W-1:0] r_src_col;
    logic [C_DIM_W-1:0] r_src_row;
    logic [C_CRD_W-1:0] r_dst_col;
    logic [C_DIM_W-1:0] r_dst_row;
    logic [C_DIM_W-1:0] r_wanted_col;
    logic [C_DIM_W-1:0] r_wanted_row;
    logic               r_out_valid;
    logic [C_PIX_W-1:0] r_out_blue;
    logic [C_PIX_W-1:0] r_out_green;
    logic [C_PIX_W-1:0] r_out_red;
    logic [C_CRD_W-1:0] r_out_col;
    logic [C_CRD_W-1:0] r_out_row;
    logic               r_frame_done;

    logic [C_CRD_W-1:0] b_src_col;
    logic [C_DIM_W-1:0] b_src_row;
    logic [C_CRD_W-1:0] b_dst_col;
    logic [C_DIM_W-1:0] b_dst_row;
    logic [C_DIM_W-1:0] want_col;
    logic [C_DIM_W-1:0] want_row;
    logic               hit;
    logic               out_free;
    logic               pop;
    logic [C_DIM_W-1:0] col_inc;
    logic [C_DIM_W-1:0] scol_inc;
    logic [C_CRD_W-1:0] n_dst_col;
    logic [C_DIM_W-1:0] n_dst_row;
    logic [C_CRD_W-1:0] n_src_col;
    logic [C_DIM_W-1:0] n_src_row;
    logic [C_DIM_W-1:0] quot_ext;

    // A start mark restarts the counters before the pixel is matched.
    always_comb begin
        b_src_col = i_head.sof ? '0 : r_src_col;
        b_src_row = i_head.sof ? '0 : r_src_row;
        b_dst_col = i_head.sof ? '0 : r_dst_col;
        b_dst_row = i_head.sof ? '0 : r_dst_row;
        want_col  = i_head.sof ? {1'b0, i_geom.offx} : r_wanted_col;
        want_row  = i_head.sof ? {1'b0, i_geom.offy} : r_wanted_row;
        hit       = (b_dst_row < i_geom.n) && (b_src_row == want_row)
                    && ({1'b0, b_src_col} == want_col);
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign pop      = (r_state == BK_READY) && !r_dirty && i_head_valid
                      && (!hit || out_free);
    assign o_pop    = pop;

    always_comb begin
        col_inc   = {1'b0, b_dst_col} + 1'b1;
        n_dst_col = b_dst_col;
        n_dst_row = b_dst_row;
        if (hit) begin
            if (col_inc >= i_geom.n) begin
                n_dst_col = '0;
                n_dst_row = b_dst_row + 1'b1;
            end else begin
                n_dst_col = col_inc[C_CRD_W-1:0];
            end
        end

        scol_inc  = {1'b0, b_src_col} + 1'b1;
        n_src_col = b_src_col;
        n_src_row = b_src_row;
        if (b_src_row < i_geom.height) begin
            if (scol_inc >= i_geom.width) begin
                n_src_col = '0;
                n_src_row = b_src_row + 1'b1;
            end else begin
                n_src_col = scol_inc[C_CRD_W-1:0];
            end
        end
        if (n_src_row > i_geom.height) begin
            n_src_row = i_geom.height;
        end
    end

    assign quot_ext = {1'b0, i_div_rsp.quot};

    // Recompute the wanted source position whenever the output position or the
    // geometry has changed: column first, then row, on the shared divider.
    always_comb begin
        n_state             = r_state;
        n_dirty             = r_dirty;
        o_div_req.start     = 1'b0;
        o_div_req.mult      = {1'b0, r_dst_col};
        o_div_req.side      = i_geom.side;
        o_div_req.divisor   = i_geom.n;
        case (r_state)
            BK_READY: begin
                if (r_dirty) begin
                    o_div_req.start = 1'b1;
                    n_dirty         = 1'b0;
                    n_state         = BK_COL;
                end
            end
            BK_COL: begin
                if (i_div_rsp.done) begin
                    o_div_req.start = 1'b1;
                    o_div_req.mult  = r_dst_row;
                    n_state         = BK_ROW;
                end
            end
            BK_ROW: begin
                if (i_div_rsp.done) begin
                    n_state = BK_READY;
                end
            end
            default: begin
                n_state = BK_READY;
            end
        endcase
        if (pop && hit) begin
            n_dirty = 1'b1;
        end
        if (i_cfg_wr) begin
            n_dirty = 1'b1;
        end
    end

    // A quotient too wide for a coordinate lies past every source pixel, so the
    // wanted position is parked at a value no counter can reach.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_READY;
            r_dirty      <= 1'b1;
            r_src_col    <= '0;
            r_src_row    <= '0;
            r_dst_col    <= '0;
            r_dst_row    <= '0;
            r_wanted_col <= '0;
            r_wanted_row <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dirty <= n_dirty;
            if (pop) begin
                r_src_col <= n_src_col;
                r_src_row <= n_src_row;
                r_dst_col <= n_dst_col;
                r_dst_row <= n_dst_row;
                if (i_head.sof) begin
                    r_wanted_col <= {1'b0, i_geom.offx};
                    r_wanted_row <= {1'b0, i_geom.offy};
                end
            end
            if ((r_state == BK_COL) && i_div_rsp.done) begin
                r_wanted_col <= i_div_rsp.ovf ? '1 : ({1'b0, i_geom.offx} + quot_ext);
            end
            if ((r_state == BK_ROW) && i_div_rsp.done) begin
                r_wanted_row <= i_div_rsp.ovf ? '1 : ({1'b0, i_geom.offy} + quot_ext);
            end
            if (out_free) begin
                r_out_valid <= pop && hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && hit) begin
            r_out_blue   <= i_head.blue;
            r_out_green  <= i_head.green;
            r_out_red    <= i_head.red;
            r_out_col    <= b_dst_col;
            r_out_row    <= b_dst_row[C_CRD_W-1:0];
            r_frame_done <= (n_dst_row >= i_geom.n);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_blue   = r_out_blue;
    assign o_out_green  = r_out_green;
    assign o_out_red    = r_out_red;
    assign o_out_col    = r_out_col;
    assign o_out_row    = r_out_row;
    assign o_frame_done = r_frame_done;

endmodule

@@ hdl/center_crop_nearest_scaler.sv @@
// Center-crop nearest-neighbor downscaler. Source pixels enter in raster order, one item
// per pixel, with start_of_frame set on the first pixel of each frame; a stream that starts
// without a mark counts as a frame begun at reset. The block crops the centered square of
// side S = min(frame_width, frame_height) and resamples it to an N x N image, N = out_size
// clamped to S, emitting each chosen source pixel once with alpha 255, its output column and
// row, and frame_done on the last output pixel of the frame. Registers are clamped to 1..4096
// when used and should be written only while the block is idle; a write takes effect at once.
// Items pass through a four-entry input queue. An item that yields no output pixel is
// retired without a recompute. After every emitted pixel, and after every register write,
// the block recomputes the next wanted source position on one shared multiply-and-divide
// unit (a multiply state plus twelve divide steps, run once for the column and once for the
// row), and the next queued item is examined only once that is done; the queue keeps
// taking items meanwhile until it is full. Since at most one source pixel in S/N is
// picked, the sustained rate stays near one item per cycle while the output does not stall
// and S/N is large, and falls for a small crop ratio, as each pick waits for a recompute.
module center_crop_nearest_scaler
    import ccns_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [C_DIM_W-1:0]     i_cfg_data,

    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [C_PIX_W-1:0]     i_pixel_blue,
    input  logic [C_PIX_W-1:0]     i_pixel_green,
    input  logic [C_PIX_W-1:0]     i_pixel_red,
    input  logic                   i_start_of_frame,

    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [C_PIX_W-1:0]     o_out_blue,
    output logic [C_PIX_W-1:0]     o_out_green,
    output logic [C_PIX_W-1:0]     o_out_red,
    output logic [C_PIX_W-1:0]     o_out_alpha,
    output logic [C_CRD_W-1:0]     o_out_col,
    output logic [C_CRD_W-1:0]     o_out_row,
    output logic                   o_frame_done
);

    // Configuration registers keep the written bits; clamping happens on use.
    logic [C_DIM_W-1:0] r_frame_width;
    logic [C_DIM_W-1:0] r_frame_height;
    logic [C_DIM_W-1:0] r_out_size;
    logic               cfg_wr;

    t_geom              geom;
    logic [C_DIM_W-1:0] w_sat;
    logic [C_DIM_W-1:0] h_sat;
    logic [C_DIM_W-1:0] n_sat;
    logic [C_DIM_W-1:0] side;
    logic [C_DIM_W-1:0] dx;
    logic [C_DIM_W-1:0] dy;

    t_item              in_item;
    t_item              head;
    logic               head_valid;
    logic               pop;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    // The port never refuses a write.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= C_DIM_W'(1920);
            r_frame_height <= C_DIM_W'(1080);
            r_out_size     <= C_DIM_W'(256);
        end else if (cfg_wr) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_OUT_SIZE:     r_out_size     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Crop geometry: square side, its centered offsets, and the clamped output side.
    always_comb begin
        w_sat = sat_dim(r_frame_width);
        h_sat = sat_dim(r_frame_height);
        n_sat = sat_dim(r_out_size);
        side  = (w_sat < h_sat) ? w_sat : h_sat;
        dx    = w_sat - side;
        dy    = h_sat - side;

        geom.width  = w_sat;
        geom.height = h_sat;
        geom.side   = side;
        geom.n      = (n_sat > side) ? side : n_sat;
        geom.offx   = dx[C_DIM_W-1:1];
        geom.offy   = dy[C_DIM_W-1:1];
    end

    assign in_item.blue  = i_pixel_blue;
    assign in_item.green = i_pixel_green;
    assign in_item.red   = i_pixel_red;
    assign in_item.sof   = i_start_of_frame;

    ccns_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_item       (in_item),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    ccns_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ccns_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (geom),
        .i_cfg_wr     (cfg_wr),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_div_req    (div_req),
        .i_div_rsp    (div_rsp),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_blue   (o_out_blue),
        .o_out_green  (o_out_green),
        .o_out_red    (o_out_red),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_frame_done (o_frame_done)
    );

    // Every output pixel is opaque.
    assign o_out_alpha = C_ALPHA_OPAQUE;

endmodule

@@ hdl/ccns_checker.sv @@
module ccns_checker
    import ccns_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [C_PIX_W-1:0]     o_out_blue,
    input logic [C_PIX_W-1:0]     o_out_green,
    input logic [C_PIX_W-1:0]     o_out_red,
    input logic [C_PIX_W-1:0]     o_out_alpha,
    input logic [C_CRD_W-1:0]     o_out_col,
    input logic [C_CRD_W-1:0]     o_out_row,
    input logic                   o_frame_done
);

    // A stalled output item stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_col)
            && $stable(o_out_row) && $stable(o_out_blue) && $stable(o_out_green)
            && $stable(o_out_red) && $stable(o_frame_done))
        else $error("output item changed while stalled");

    // The last pixel of a frame sits in the last output row and at or past the last
    // column, so its column is never below its row.
    a_done_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_out_col >= o_out_row)
        else $error("frame end flagged off the last output pixel");

    // Output pixels are always opaque.
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_alpha == C_ALPHA_OPAQUE)
        else $error("alpha not opaque");

    // The input queue can only fill up after taking an item.
    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("input stall rose without an accepted item");

endmodule

bind center_crop_nearest_scaler ccns_checker u_ccns_checker (.*);
